// ===== rtl/bpd_pkg.sv =====
// Shared widths, stage counts and codes for the bond price and duration pipeline.
// No dependencies; every rtl file imports it.
package bpd_pkg;

	localparam int RATE_FRAC_BITS = 20;

	localparam int YEARS_W = 6;
	localparam int PER_W   = 4;
	localparam int FACE_W  = 20;
	localparam int YIELD_W = 20;
	localparam int CPN_W   = 19;
	localparam int BUMP_W  = 17;
	localparam int PRICE_W = 48;
	localparam int DUR_W   = 32;
	localparam int STAT_W  = 2;

	localparam logic [BUMP_W-1:0] BUMP_RESET = BUMP_W'(10486);

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BUMP = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

	localparam int Q32     = 32;
	localparam int RATE_W  = YIELD_W + 1;
	localparam int R_SH    = Q32 - RATE_FRAC_BITS;
	localparam int R_W     = RATE_W + R_SH;
	localparam int N_W     = YEARS_W + PER_W;
	localparam int CF_W    = CPN_W + FACE_W;
	localparam int V_W     = Q32 + 1;
	localparam int D_W     = Q32 + 2;
	localparam int MUL_W   = 2 * V_W;

	// per-period rate division
	localparam int PD_STEPS = 7;
	localparam int PD_ST    = (R_W + PD_STEPS - 1) / PD_STEPS;
	localparam int PDX_W    = PD_ST * PD_STEPS;

	// discount factor division
	localparam int VD_STEPS = 2;
	localparam int VD_ST    = Q32 / VD_STEPS;

	// power by square and multiply
	localparam int PW_ST = N_W;

	// annuity division
	localparam int ANN_SH   = 24;
	localparam int A_W      = 36;
	localparam int AD_STEPS = 2;
	localparam int AD_ST    = A_W / AD_STEPS;
	localparam int NUM_W    = V_W + ANN_SH;
	localparam int NUM_TOP  = NUM_W - A_W;

	// price assembly
	localparam int PRICE_FRAC = 16;
	localparam int FZ_W    = FACE_W + V_W;
	localparam int ZERO_W  = FZ_W - (Q32 - PRICE_FRAC);
	localparam int A_LO    = A_W / 2;
	localparam int PL_W    = CF_W + A_LO;
	localparam int PROD_W  = CF_W + A_W;
	localparam int CT_SH   = RATE_FRAC_BITS + 8;
	localparam int CT_W    = PROD_W - CT_SH;
	localparam int SUM_W   = PRICE_W + 1;

	// duration division
	localparam int DUR_SH   = RATE_FRAC_BITS + 15;
	localparam int DEN_W    = PRICE_W + BUMP_W;
	localparam int RM0_SH   = DUR_SH - DUR_W;
	localparam int RM0_W    = PRICE_W + RM0_SH;
	localparam int DD_STEPS = 2;
	localparam int DD_ST    = DUR_W / DD_STEPS;

	localparam int LANE_LAT = PD_ST + VD_ST + PW_ST + AD_ST + 3;
	localparam int DUR_LAT  = DD_ST + 3;
	localparam int TOT_LAT  = 1 + LANE_LAT + DUR_LAT;

endpackage

// ===== rtl/bpd_lane.sv =====
// One pricing lane: per-period rate, discount factor, power, annuity and price.
// Depends on bpd_pkg; fully pipelined, advances on adv.
module bpd_lane
	import bpd_pkg::*;
(
	input  logic               clk,
	input  logic               adv,
	input  logic [N_W-1:0]     n,
	input  logic [PER_W-1:0]   per,
	input  logic [FACE_W-1:0]  face,
	input  logic [CF_W-1:0]    cpnf,
	input  logic [RATE_W-1:0]  rate,
	output logic [PRICE_W-1:0] price,
	output logic               sat
);

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [PER_W-1:0]  per;
		logic [FACE_W-1:0] face;
		logic [CF_W-1:0]   cpnf;
		logic [PDX_W-1:0]  x;
		logic [PER_W-1:0]  rem;
		logic [PDX_W-1:0]  q;
	} pd_t;

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [FACE_W-1:0] face;
		logic [CF_W-1:0]   cpnf;
		logic [R_W-1:0]    r;
		logic [D_W-1:0]    dv;
		logic [D_W-1:0]    rem;
		logic [Q32-1:0]    q;
	} vd_t;

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [FACE_W-1:0] face;
		logic [CF_W-1:0]   cpnf;
		logic [R_W-1:0]    r;
		logic [N_W-1:0]    nb;
		logic [V_W-1:0]    acc;
		logic [V_W-1:0]    base;
	} pw_t;

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [FACE_W-1:0] face;
		logic [CF_W-1:0]   cpnf;
		logic [R_W-1:0]    r;
		logic [V_W-1:0]    vn;
		logic [R_W-1:0]    rem;
		logic [A_W-1:0]    x;
		logic [A_W-1:0]    q;
	} ad_t;

	typedef struct packed {
		logic [ZERO_W-1:0] zero;
		logic [PL_W-1:0]   pl;
		logic [PL_W-1:0]   ph;
	} pa_t;

	typedef struct packed {
		logic [ZERO_W-1:0] zero;
		logic [CT_W-1:0]   cterm;
	} pb_t;

	pd_t pd_w [PD_ST+1];
	vd_t vd_w [VD_ST+1];
	pw_t pw_w [PW_ST+1];
	ad_t ad_w [AD_ST+1];

	pa_t pa_s1;
	pb_t pb_s2;

	logic [V_W-1:0]   v_in;
	logic [V_W-1:0]   num_in;
	logic [NUM_W-1:0] numw_in;
	logic [A_W-1:0]   ann;
	logic [FZ_W-1:0]  fz;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  total;

	// rate / periods
	assign pd_w[0] = '{n: n, per: per, face: face, cpnf: cpnf,
		x: PDX_W'({rate, {R_SH{1'b0}}}), rem: '0, q: '0};

	for (genvar g = 0; g < PD_ST; g++) begin : g_pd
		pd_t nx;
		pd_t st_s;
		logic [PER_W:0] t;
		always_comb begin
			nx = pd_w[g];
			t = '0;
			for (int k = 0; k < PD_STEPS; k++) begin
				t = {nx.rem, nx.x[PDX_W-1]};
				nx.x = {nx.x[PDX_W-2:0], 1'b0};
				if (t >= {1'b0, nx.per}) begin
					nx.rem = PER_W'(t - {1'b0, nx.per});
					nx.q = {nx.q[PDX_W-2:0], 1'b1};
				end else begin
					nx.rem = t[PER_W-1:0];
					nx.q = {nx.q[PDX_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s <= nx;
			end
		end
		assign pd_w[g+1] = st_s;
	end

	// discount factor: all-ones dividend over 2^32 + r
	assign vd_w[0] = '{n: pd_w[PD_ST].n, face: pd_w[PD_ST].face, cpnf: pd_w[PD_ST].cpnf,
		r: pd_w[PD_ST].q[R_W-1:0],
		dv: D_W'(pd_w[PD_ST].q[R_W-1:0]) + (D_W'(1) << Q32),
		rem: D_W'({Q32{1'b1}}), q: '0};

	for (genvar g = 0; g < VD_ST; g++) begin : g_vd
		vd_t nx;
		vd_t st_s;
		logic [D_W:0] t;
		always_comb begin
			nx = vd_w[g];
			t = '0;
			for (int k = 0; k < VD_STEPS; k++) begin
				t = {nx.rem, 1'b1};
				if (t >= {1'b0, nx.dv}) begin
					nx.rem = D_W'(t - {1'b0, nx.dv});
					nx.q = {nx.q[Q32-2:0], 1'b1};
				end else begin
					nx.rem = t[D_W-1:0];
					nx.q = {nx.q[Q32-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s <= nx;
			end
		end
		assign vd_w[g+1] = st_s;
	end

	// power
	assign v_in = (vd_w[VD_ST].r == '0) ? (V_W'(1) << Q32) : {1'b0, vd_w[VD_ST].q};
	assign pw_w[0] = '{n: vd_w[VD_ST].n, face: vd_w[VD_ST].face, cpnf: vd_w[VD_ST].cpnf,
		r: vd_w[VD_ST].r, nb: vd_w[VD_ST].n, acc: V_W'(1) << Q32, base: v_in};

	for (genvar g = 0; g < PW_ST; g++) begin : g_pw
		pw_t nx;
		pw_t st_s;
		logic [MUL_W-1:0] ma;
		logic [MUL_W-1:0] mb;
		always_comb begin
			nx = pw_w[g];
			ma = MUL_W'(nx.acc) * MUL_W'(nx.base);
			mb = MUL_W'(nx.base) * MUL_W'(nx.base);
			if (nx.nb[0]) begin
				nx.acc = ma[Q32 +: V_W];
			end
			nx.base = mb[Q32 +: V_W];
			nx.nb = nx.nb >> 1;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s <= nx;
			end
		end
		assign pw_w[g+1] = st_s;
	end

	// annuity factor
	assign num_in = (V_W'(1) << Q32) - pw_w[PW_ST].acc;
	assign numw_in = {num_in, {ANN_SH{1'b0}}};
	assign ad_w[0] = '{n: pw_w[PW_ST].n, face: pw_w[PW_ST].face, cpnf: pw_w[PW_ST].cpnf,
		r: pw_w[PW_ST].r, vn: pw_w[PW_ST].acc,
		rem: R_W'(numw_in[NUM_W-1 -: NUM_TOP]), x: numw_in[A_W-1:0], q: '0};

	for (genvar g = 0; g < AD_ST; g++) begin : g_ad
		ad_t nx;
		ad_t st_s;
		logic [R_W:0] t;
		always_comb begin
			nx = ad_w[g];
			t = '0;
			for (int k = 0; k < AD_STEPS; k++) begin
				t = {nx.rem, nx.x[A_W-1]};
				nx.x = {nx.x[A_W-2:0], 1'b0};
				if (t >= {1'b0, nx.r}) begin
					nx.rem = R_W'(t - {1'b0, nx.r});
					nx.q = {nx.q[A_W-2:0], 1'b1};
				end else begin
					nx.rem = t[R_W-1:0];
					nx.q = {nx.q[A_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s <= nx;
			end
		end
		assign ad_w[g+1] = st_s;
	end

	// price
	assign ann = (ad_w[AD_ST].r == '0) ? A_W'({ad_w[AD_ST].n, {ANN_SH{1'b0}}}) : ad_w[AD_ST].q;
	assign fz = FZ_W'(ad_w[AD_ST].face) * FZ_W'(ad_w[AD_ST].vn);
	assign prod = PROD_W'(pa_s1.pl) + (PROD_W'(pa_s1.ph) << A_LO);
	assign total = SUM_W'(pb_s2.zero) + SUM_W'(pb_s2.cterm);

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1.zero <= fz[FZ_W-1 -: ZERO_W];
			pa_s1.pl <= PL_W'(ad_w[AD_ST].cpnf) * PL_W'(ann[A_LO-1:0]);
			pa_s1.ph <= PL_W'(ad_w[AD_ST].cpnf) * PL_W'(ann[A_W-1:A_LO]);
			pb_s2.zero <= pa_s1.zero;
			pb_s2.cterm <= prod[PROD_W-1:CT_SH];
			sat <= total[PRICE_W];
			price <= total[PRICE_W] ? {PRICE_W{1'b1}} : total[PRICE_W-1:0];
		end
	end

endmodule

// ===== rtl/bpd_dur.sv =====
// Effective duration from the three lane prices, status, and the output register.
// Depends on bpd_pkg; fully pipelined, advances on adv.
module bpd_dur
	import bpd_pkg::*;
(
	input  logic               clk,
	input  logic               adv,
	input  logic [BUMP_W-1:0]  bump,
	input  logic [PRICE_W-1:0] p0,
	input  logic [PRICE_W-1:0] pm,
	input  logic [PRICE_W-1:0] pp,
	input  logic               sat_any,
	input  logic               bad,
	output logic [PRICE_W-1:0] price,
	output logic [DUR_W-1:0]   duration,
	output logic [STAT_W-1:0]  status
);

	typedef struct packed {
		logic [PRICE_W-1:0] p0;
		logic               sat;
		logic               bad;
		logic               go;
		logic [PRICE_W-1:0] diff;
		logic [DEN_W-1:0]   den;
	} d1_t;

	typedef struct packed {
		logic [PRICE_W-1:0] p0;
		logic               sat;
		logic               bad;
		logic               go;
		logic               dsat;
		logic [DEN_W-1:0]   den;
		logic [DEN_W-1:0]   rem;
		logic [DUR_W-1:0]   q;
	} dv_t;

	d1_t d1_s1;
	dv_t dv_w [DD_ST+1];

	logic [BUMP_W-1:0] dd;
	logic [RM0_W-1:0]  rem0;
	logic              dsat0;
	dv_t               fin;

	assign dd = (bump == '0) ? BUMP_W'(1) : bump;

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1.p0 <= p0;
			d1_s1.sat <= sat_any;
			d1_s1.bad <= bad;
			d1_s1.go <= !bad && (p0 != '0) && (pm > pp);
			d1_s1.diff <= pm - pp;
			d1_s1.den <= DEN_W'(p0) * DEN_W'(dd);
		end
	end

	assign rem0 = {d1_s1.diff, {RM0_SH{1'b0}}};
	assign dsat0 = d1_s1.go && (DEN_W'(rem0) >= d1_s1.den);

	dv_t d2_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s2 <= '{p0: d1_s1.p0, sat: d1_s1.sat, bad: d1_s1.bad, go: d1_s1.go,
				dsat: dsat0, den: d1_s1.den, rem: DEN_W'(rem0), q: '0};
		end
	end
	assign dv_w[0] = d2_s2;

	for (genvar g = 0; g < DD_ST; g++) begin : g_dd
		dv_t nx;
		dv_t st_s;
		logic [DEN_W:0] t;
		always_comb begin
			nx = dv_w[g];
			t = '0;
			for (int k = 0; k < DD_STEPS; k++) begin
				t = {nx.rem, 1'b0};
				if (t >= {1'b0, nx.den}) begin
					nx.rem = DEN_W'(t - {1'b0, nx.den});
					nx.q = {nx.q[DUR_W-2:0], 1'b1};
				end else begin
					nx.rem = t[DEN_W-1:0];
					nx.q = {nx.q[DUR_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s <= nx;
			end
		end
		assign dv_w[g+1] = st_s;
	end

	assign fin = dv_w[DD_ST];

	always_ff @(posedge clk) begin
		if (adv) begin
			price <= fin.p0;
			if (!fin.go) begin
				duration <= '0;
			end else if (fin.dsat) begin
				duration <= {DUR_W{1'b1}};
			end else begin
				duration <= fin.q;
			end
			if (fin.bad) begin
				status <= ST_BUMP;
			end else if (fin.sat || fin.dsat) begin
				status <= ST_SAT;
			end else begin
				status <= ST_OK;
			end
		end
	end

endmodule

// ===== rtl/bond_price_effective_duration_unit.sv =====
// Bond price and effective duration unit: top level, bump register, valid line.
// Depends on bpd_pkg, bpd_lane and bpd_dur.
//
// Usage:
// - Input channel: in_valid / in_stall with one bond per word (years,
//   periods_per_year, face_value, yield_rate, coupon_rate).
// - Output channel: out_valid / out_stall with price, duration and status.
// - cfg_wr_en / cfg_wr_data write the yield bump; write only while idle.
// - Throughput: one word per cycle, every cycle, while the output is not stalled.
// - Pipeline depth: TOT_LAT = 72 register stages, the input register included.
//   The depth is set by three restoring dividers (rate by periods, discount
//   factor, annuity) in each of three parallel price lanes, a ten-stage
//   square-and-multiply power, and a 32-bit restoring divider for the duration.
// - Reset clears the valid line and loads the bump with its default.
// - When out_valid is held off by out_stall the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
module bond_price_effective_duration_unit
	import bpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [BUMP_W-1:0]  cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [YEARS_W-1:0] years,
	input  logic [PER_W-1:0]   periods_per_year,
	input  logic [FACE_W-1:0]  face_value,
	input  logic [YIELD_W-1:0] yield_rate,
	input  logic [CPN_W-1:0]   coupon_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PRICE_W-1:0] price,
	output logic [DUR_W-1:0]   duration,
	output logic [STAT_W-1:0]  status
);

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [PER_W-1:0]  per;
		logic [FACE_W-1:0] face;
		logic [CF_W-1:0]   cpnf;
		logic [RATE_W-1:0] y0;
		logic [RATE_W-1:0] ym;
		logic [RATE_W-1:0] yp;
		logic              bad;
	} in_t;

	logic [BUMP_W-1:0]  bump_q;
	logic [TOT_LAT-1:0] vld_s;
	logic [LANE_LAT-1:0] bad_s;
	in_t                in_s1;

	logic              adv;
	logic [BUMP_W-1:0] d;
	logic [PER_W-1:0]  per1;

	logic [PRICE_W-1:0] p0;
	logic [PRICE_W-1:0] pm;
	logic [PRICE_W-1:0] pp;
	logic               s0;
	logic               sm;
	logic               sp;

	assign adv = !(vld_s[TOT_LAT-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_s[TOT_LAT-1];

	assign d = (bump_q == '0) ? BUMP_W'(1) : bump_q;
	assign per1 = (periods_per_year == '0) ? PER_W'(1) : periods_per_year;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q <= BUMP_RESET;
			vld_s <= '0;
		end else begin
			if (cfg_wr_en) begin
				bump_q <= cfg_wr_data;
			end
			if (adv) begin
				vld_s <= {vld_s[TOT_LAT-2:0], in_valid};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1.n <= N_W'(years) * N_W'(per1);
			in_s1.per <= per1;
			in_s1.face <= face_value;
			in_s1.cpnf <= CF_W'(coupon_rate) * CF_W'(face_value);
			in_s1.y0 <= RATE_W'(yield_rate);
			in_s1.ym <= RATE_W'(yield_rate) - RATE_W'(d);
			in_s1.yp <= RATE_W'(yield_rate) + RATE_W'(d);
			in_s1.bad <= RATE_W'(yield_rate) <= RATE_W'(d);
			bad_s <= {bad_s[LANE_LAT-2:0], in_s1.bad};
		end
	end

	bpd_lane u_lane_p0 (
		.clk   (clk),
		.adv   (adv),
		.n     (in_s1.n),
		.per   (in_s1.per),
		.face  (in_s1.face),
		.cpnf  (in_s1.cpnf),
		.rate  (in_s1.y0),
		.price (p0),
		.sat   (s0)
	);

	bpd_lane u_lane_pm (
		.clk   (clk),
		.adv   (adv),
		.n     (in_s1.n),
		.per   (in_s1.per),
		.face  (in_s1.face),
		.cpnf  (in_s1.cpnf),
		.rate  (in_s1.ym),
		.price (pm),
		.sat   (sm)
	);

	bpd_lane u_lane_pp (
		.clk   (clk),
		.adv   (adv),
		.n     (in_s1.n),
		.per   (in_s1.per),
		.face  (in_s1.face),
		.cpnf  (in_s1.cpnf),
		.rate  (in_s1.yp),
		.price (pp),
		.sat   (sp)
	);

	bpd_dur u_dur (
		.clk      (clk),
		.adv      (adv),
		.bump     (bump_q),
		.p0       (p0),
		.pm       (pm),
		.pp       (pp),
		.sat_any  (s0 | sm | sp),
		.bad      (bad_s[LANE_LAT-1]),
		.price    (price),
		.duration (duration),
		.status   (status)
	);

endmodule

// ===== tb/tb_bond_price_effective_duration_unit.sv =====
// Testbench for the bond price and effective duration unit.
// Drives bonds over a valid/stall channel, predicts price, duration and status
// in fixed point and checks each result in order; depends on bpd_pkg and the rtl.
`timescale 1ns / 1ps

module tb_bond_price_effective_duration_unit;
	import bpd_pkg::*;

	typedef struct packed {
		logic [YEARS_W-1:0] years;
		logic [PER_W-1:0]   per;
		logic [FACE_W-1:0]  face;
		logic [YIELD_W-1:0] yld;
		logic [CPN_W-1:0]   cpn;
	} bond_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [DUR_W-1:0]   duration;
		logic [STAT_W-1:0]  status;
	} quote_t;

	localparam logic [63:0]  ONE32     = 64'd1 << 32;
	localparam logic [63:0]  PRICE_TOP = (64'd1 << PRICE_W) - 1;
	localparam logic [127:0] DUR_TOP   = 128'hFFFF_FFFF;
	localparam int           DRAIN     = TOT_LAT + 10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [BUMP_W-1:0]  cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [YEARS_W-1:0] years = '0;
	logic [PER_W-1:0]   periods_per_year = '0;
	logic [FACE_W-1:0]  face_value = '0;
	logic [YIELD_W-1:0] yield_rate = '0;
	logic [CPN_W-1:0]   coupon_rate = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PRICE_W-1:0] price;
	logic [DUR_W-1:0]   duration;
	logic [STAT_W-1:0]  status;

	logic [BUMP_W-1:0] bump_reg;
	quote_t            quote_q[$];
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                n_fail = 0;

	bond_price_effective_duration_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .years(years),
		.periods_per_year(periods_per_year), .face_value(face_value),
		.yield_rate(yield_rate), .coupon_rate(coupon_rate), .out_valid(out_valid),
		.out_stall(out_stall), .price(price), .duration(duration), .status(status)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] bond_value(logic [63:0] n, logic [63:0] p,
			logic [63:0] face, logic [63:0] rate, logic [63:0] cpn, inout bit sat);
		logic [63:0]  r, vn, ann, base, k, zero_part;
		logic [127:0] prod, total;
		r = (rate << (32 - RATE_FRAC_BITS)) / p;
		if (r == 0) begin
			vn = ONE32;
			ann = n << 24;
		end else begin
			base = 64'hFFFF_FFFF_FFFF_FFFF / (ONE32 + r);
			vn = ONE32;
			k = n;
			while (k != 0) begin
				if (k[0]) vn = (vn * base) >> 32;
				base = (base * base) >> 32;
				k = k >> 1;
			end
			ann = ((ONE32 - vn) << 24) / r;
		end
		zero_part = (face * vn) >> 16;
		prod = (128'(cpn * face) * 128'(ann)) >> (RATE_FRAC_BITS + 8);
		total = prod + 128'(zero_part);
		if (prod > 128'(PRICE_TOP) || total > 128'(PRICE_TOP)) begin
			sat = 1'b1;
			return PRICE_TOP;
		end
		return total[63:0];
	endfunction

	function automatic quote_t quote_bond(bond_t b);
		logic [63:0]  d, p, n, p0, pm, pp;
		logic [127:0] num, den, q;
		bit           sat;
		quote_t       res;
		sat = 1'b0;
		d = (bump_reg == 0) ? 64'd1 : 64'(bump_reg);
		p = (b.per == 0) ? 64'd1 : 64'(b.per);
		n = 64'(b.years) * p;
		p0 = bond_value(n, p, b.face, b.yld, b.cpn, sat);
		res.price = p0[PRICE_W-1:0];
		res.duration = '0;
		res.status = ST_OK;
		if (64'(b.yld) <= d) begin
			res.status = ST_BUMP;
		end else begin
			pm = bond_value(n, p, b.face, 64'(b.yld) - d, b.cpn, sat);
			pp = bond_value(n, p, b.face, 64'(b.yld) + d, b.cpn, sat);
			if (p0 != 0 && pm > pp) begin
				num = 128'(pm - pp) << DUR_SH;
				den = 128'(p0) * 128'(d);
				if (num >= (den << 32)) begin
					q = DUR_TOP;
					sat = 1'b1;
				end else begin
					q = num / den;
				end
				res.duration = q[DUR_W-1:0];
			end
			if (sat) res.status = ST_SAT;
		end
		return res;
	endfunction

	task automatic send_bond(bond_t b);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		years <= b.years;
		periods_per_year <= b.per;
		face_value <= b.face;
		yield_rate <= b.yld;
		coupon_rate <= b.cpn;
		do @(posedge clk); while (in_stall);
		quote_q.push_back(quote_bond(b));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (quote_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_bump(logic [BUMP_W-1:0] val);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bump_reg = val;
	endtask

	function automatic bond_t random_bond();
		bond_t b;
		int    sel;
		sel = $urandom_range(99);
		b.years = (sel < 85) ? YEARS_W'($urandom_range(50, 1)) : YEARS_W'($urandom);
		b.per = (sel < 85) ? PER_W'($urandom_range(12, 1)) : PER_W'($urandom);
		b.face = (sel < 60) ? FACE_W'($urandom_range(1000000, 1)) : FACE_W'($urandom);
		case ($urandom_range(3))
			0: b.yld = YIELD_W'($urandom);
			1: b.yld = YIELD_W'(32'(bump_reg) + $urandom_range(4, 0));
			default: b.yld = YIELD_W'($urandom_range(524288, 0));
		endcase
		b.cpn = ($urandom_range(5) == 0) ? '0 :
			(sel < 85) ? CPN_W'($urandom_range(262144, 0)) : CPN_W'($urandom);
		return b;
	endfunction

	task automatic send_random(int count);
		repeat (count) send_bond(random_bond());
	endtask

	task automatic test_directed();
		bond_t b;
		int    i;
		for (i = 0; i < 22; i++) begin
			b.years = (i % 4 == 0) ? 6'd1 : (i % 4 == 1) ? 6'd50 : (i % 4 == 2) ? 6'd0 : 6'd63;
			b.per = (i % 5 == 0) ? 4'd0 : (i % 5 == 1) ? 4'd1 : (i % 5 == 2) ? 4'd12 :
				(i % 5 == 3) ? 4'd15 : 4'd2;
			b.face = (i % 3 == 0) ? 20'd1 : (i % 3 == 1) ? 20'd1000000 : 20'hFFFFF;
			case (i % 6)
				0: b.yld = '0;
				1: b.yld = YIELD_W'(bump_reg);
				2: b.yld = YIELD_W'(bump_reg) + 1'b1;
				3: b.yld = 20'd524288;
				4: b.yld = 20'hFFFFF;
				default: b.yld = 20'd52429;
			endcase
			b.cpn = (i % 4 == 0) ? 19'd0 : (i % 4 == 1) ? 19'd262144 :
				(i % 4 == 2) ? 19'h7FFFF : 19'd26214;
			send_bond(b);
		end
	endtask

	task automatic test_idle_phases();
		idle_pct = 0;  stall_pct = 0;  send_random(150);
		idle_pct = 54; stall_pct = 0;  send_random(150);
		idle_pct = 0;  stall_pct = 54; send_random(150);
		idle_pct = 17; stall_pct = 17; send_random(150);
		idle_pct = 0;  stall_pct = 0;  send_random(100);
	endtask

	task automatic test_bump_sweep();
		write_bump(BUMP_W'(1));       send_random(100);
		write_bump(BUMP_W'(65536));   send_random(100);
		idle_pct = 17; stall_pct = 17;
		write_bump(BUMP_W'(0));       send_random(100);
		write_bump(BUMP_W'(131071));  send_random(100);
		idle_pct = 54; stall_pct = 54;
		write_bump(BUMP_W'($urandom_range(65536, 1))); send_random(100);
		write_bump(BUMP_RESET);       send_random(100);
		idle_pct = 0; stall_pct = 0;
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (quote_q.size() == 0) begin
				n_fail++;
				$display("%0t unexpected word price=%0d duration=%0d status=%0d",
					$time, price, duration, status);
			end else begin
				quote_t e;
				e = quote_q.pop_front();
				if (e.price !== price || e.duration !== duration || e.status !== status) begin
					n_fail++;
					$display("%0t mismatch exp price=%0d dur=%0d st=%0d got %0d %0d %0d",
						$time, e.price, e.duration, e.status, price, duration, status);
				end
			end
		end
	end

	initial begin
		bump_reg = BUMP_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_phases();
		test_bump_sweep();
		drain_results();
		if (n_fail == 0 && quote_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
